FILE: hw/rtl/ahdsr_pkg.sv
// shared types, constants and helpers for the ahdsr envelope generator
`default_nettype none
package ahdsr_pkg;

  localparam int TIME_BITS = 24;
  localparam int FRAC_BITS = 15;
  localparam int REG_BITS  = 24;
  localparam int LEVEL_W   = 16;
  localparam int PHASE_W   = 2;
  localparam int KIND_W    = 2;
  localparam int SLOPE_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int END_W    = ((TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS) + 2;
  localparam int DIVD_W   = LEVEL_W + FRAC_BITS;
  localparam int PROD_W   = TIME_BITS + SLOPE_W;
  localparam int RAMP_W   = PROD_W - FRAC_BITS;
  localparam int SH_W     = (DIVD_W > TIME_BITS) ? DIVD_W : TIME_BITS;
  localparam int CNT_W    = $clog2(SH_W + 1);
  localparam int DIV_ALIGN = SH_W - DIVD_W;
  localparam int MUL_ALIGN = SH_W - TIME_BITS;
  localparam int SAT_W    = (DIVD_W > SLOPE_W + 1) ? DIVD_W : SLOPE_W + 1;
  localparam int S_DATA_W = ((TIME_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((LEVEL_W + PHASE_W + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0]  FULL_SCALE      = LEVEL_W'(32768);
  localparam logic [REG_BITS-1:0] ATTACK_RESET    = REG_BITS'(2400);
  localparam logic [REG_BITS-1:0] HOLD_RESET      = '0;
  localparam logic [REG_BITS-1:0] DECAY_RESET     = '0;
  localparam logic [LEVEL_W-1:0]  SUSTAIN_RESET   = FULL_SCALE;
  localparam logic [REG_BITS-1:0] RELEASE_RESET   = REG_BITS'(2400);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2,
    KIND_SILENCE  = 2'd3
  } kind_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_SILENCE = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_HOLD    = 3'd1,
    REG_DECAY   = 3'd2,
    REG_SUSTAIN = 3'd3,
    REG_RELEASE = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic                 start;
    alu_op_t              op;
    logic [SH_W-1:0]      operand;
    logic [SLOPE_W-1:0]   mcand;
    logic [REG_BITS-1:0]  divisor;
  } alu_cmd_t;

  typedef struct packed {
    logic                done;
    logic [DIVD_W-1:0]   quot;
    logic [PROD_W-1:0]   prod;
  } alu_stat_t;

  typedef struct packed {
    logic [REG_BITS-1:0] attack;
    logic [REG_BITS-1:0] hold;
    logic [REG_BITS-1:0] decay;
    logic [LEVEL_W-1:0]  sustain;
    logic [REG_BITS-1:0] release_len;
  } cfg_regs_t;

  function automatic logic [SLOPE_W-1:0] slope_fix(input logic [DIVD_W-1:0] q,
                                                    input logic zero_len);
    logic [SAT_W-1:0] qw;
    qw = SAT_W'(q);
    if (zero_len) return '0;
    if (qw > SAT_W'({SLOPE_W{1'b1}})) return '1;
    return qw[SLOPE_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ahdsr_envelope_generator.sv
// top level: envelope sequencer around the shared serial unit
//
//  channel | signals                              | content
//  s       | s_tvalid s_tready s_tdata s_tuser    | tdata: sample_time; tuser: kind
//  m       | m_tvalid m_tready m_tdata            | tdata: level, phase
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register writes, always ready
//
// note-on: two serial divisions, one quotient bit per cycle
// note-off in attack: one division; otherwise the item is ignored
// sample tick: one shift-add multiply while a ramp is running, one bit of dt per cycle
// silence: no serial step; s_tready is high only while the sequencer is idle
// a result waits in the output register while the next item is taken
// synchronous reset, no clearing pass
`default_nettype none
module ahdsr_envelope_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ahdsr_pkg::S_DATA_W-1:0]     s_tdata,   // sample_time
  input  logic [ahdsr_pkg::KIND_W-1:0]       s_tuser,   // kind
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ahdsr_pkg::M_DATA_W-1:0]     m_tdata,   // level, phase, zero pad
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ahdsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ahdsr_pkg::REG_BITS-1:0]     cfg_data
);
  import ahdsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DIV_ATK = 7'b0000010,
    S_DIV_DEC = 7'b0000100,
    S_DIV_REL = 7'b0001000,
    S_CLASS   = 7'b0010000,
    S_MUL     = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t              state;
  phase_t              mode;
  cfg_regs_t           regs;
  alu_cmd_t            cmd;
  alu_stat_t           stat;

  logic [END_W-1:0]     hold_end;
  logic [END_W-1:0]     decay_end;
  logic [SLOPE_W-1:0]   attack_slope;
  logic [SLOPE_W-1:0]   decay_slope;
  logic [TIME_BITS-1:0] release_start;
  logic [END_W-1:0]     release_end;
  logic [SLOPE_W-1:0]   release_slope;
  logic [TIME_BITS-1:0] t_lat;
  logic [LEVEL_W-1:0]   level;
  logic [LEVEL_W-1:0]   ramp_base;
  logic                 ramp_sub;

  logic                 in_acc;
  kind_t                kind;
  logic [TIME_BITS-1:0] t_in;
  logic [END_W-1:0]     t_ext;
  logic                 c_atk;
  logic                 c_hold;
  logic                 c_dec;
  logic                 c_rel;
  logic                 c_fwd;
  logic [TIME_BITS-1:0] dt_dec;
  logic [TIME_BITS-1:0] dt_fwd;
  logic [TIME_BITS-1:0] dt_back;
  logic [RAMP_W-1:0]    ramp;
  logic [RAMP_W:0]      ramp_sum;
  logic [LEVEL_W-1:0]   add_lvl;
  logic [LEVEL_W-1:0]   sub_lvl;
  logic                 out_free;
  logic                 start_next;

  ahdsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  ahdsr_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign kind     = kind_t'(s_tuser);
  assign t_in     = s_tdata[TIME_BITS-1:0];
  assign out_free = !m_tvalid || m_tready;

  assign t_ext   = END_W'(t_lat);
  assign c_atk   = t_ext < END_W'(regs.attack);
  assign c_hold  = t_ext < hold_end;
  assign c_dec   = t_ext < decay_end;
  assign c_rel   = t_ext < release_end;
  assign c_fwd   = t_lat >= release_start;
  assign dt_dec  = TIME_BITS'(t_ext - hold_end);
  assign dt_fwd  = t_lat - release_start;
  assign dt_back = release_start - t_lat;

  assign ramp     = stat.prod[PROD_W-1:FRAC_BITS];
  assign ramp_sum = (RAMP_W+1)'(ramp) + (RAMP_W+1)'(ramp_base);
  assign add_lvl  = (ramp_sum > (RAMP_W+1)'(FULL_SCALE)) ? FULL_SCALE
                                                        : ramp_sum[LEVEL_W-1:0];
  assign sub_lvl  = (ramp >= RAMP_W'(ramp_base)) ? '0
                                                 : ramp_base - ramp[LEVEL_W-1:0];

  // serial unit launch points
  assign start_next =
      ((state == S_IDLE) && in_acc &&
       ((kind == KIND_NOTE_ON) || ((kind == KIND_NOTE_OFF) && (mode == PH_ATTACK)))) ||
      ((state == S_DIV_ATK) && stat.done) ||
      ((state == S_CLASS) && (mode == PH_ATTACK) && (c_atk || (!c_hold && c_dec))) ||
      ((state == S_CLASS) && (mode == PH_RELEASE) && c_rel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= PH_SILENCE;
      m_tvalid  <= 1'b0;
      cmd.start <= 1'b0;
    end else begin
      cmd.start <= start_next;
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (kind)
              KIND_NOTE_ON: begin
                mode        <= PH_ATTACK;
                hold_end    <= END_W'(regs.attack) + END_W'(regs.hold);
                decay_end   <= END_W'(regs.attack) + END_W'(regs.hold)
                               + END_W'(regs.decay);
                cmd.op      <= OP_DIV;
                cmd.operand <= SH_W'({FULL_SCALE, {FRAC_BITS{1'b0}}});
                cmd.divisor <= regs.attack;
                state       <= S_DIV_ATK;
              end
              KIND_NOTE_OFF: begin
                if (mode == PH_ATTACK) begin
                  mode          <= PH_RELEASE;
                  release_start <= t_in;
                  release_end   <= END_W'(t_in) + END_W'(regs.release_len);
                  cmd.op        <= OP_DIV;
                  cmd.operand   <= SH_W'({regs.sustain, {FRAC_BITS{1'b0}}});
                  cmd.divisor   <= regs.release_len;
                  state         <= S_DIV_REL;
                end
              end
              KIND_SILENCE: begin
                mode <= PH_SILENCE;
              end
              default: begin
                t_lat <= t_in;
                state <= S_CLASS;
              end
            endcase
          end
        end
        S_DIV_ATK: begin
          if (stat.done) begin
            attack_slope <= slope_fix(stat.quot, regs.attack == '0);
            cmd.op       <= OP_DIV;
            cmd.operand  <= SH_W'({FULL_SCALE - regs.sustain, {FRAC_BITS{1'b0}}});
            cmd.divisor  <= regs.decay;
            state        <= S_DIV_DEC;
          end
        end
        S_DIV_DEC: begin
          if (stat.done) begin
            decay_slope <= slope_fix(stat.quot, regs.decay == '0);
            state       <= S_IDLE;
          end
        end
        S_DIV_REL: begin
          if (stat.done) begin
            release_slope <= slope_fix(stat.quot, regs.release_len == '0);
            state         <= S_IDLE;
          end
        end
        S_CLASS: begin
          cmd.op <= OP_MUL;
          case (mode)
            PH_ATTACK: begin
              if (c_atk) begin
                cmd.operand <= SH_W'(t_lat);
                cmd.mcand   <= attack_slope;
                ramp_base   <= '0;
                ramp_sub    <= 1'b0;
                state       <= S_MUL;
              end else if (c_hold) begin
                level <= FULL_SCALE;
                state <= S_EMIT;
              end else if (c_dec) begin
                cmd.operand <= SH_W'(dt_dec);
                cmd.mcand   <= decay_slope;
                ramp_base   <= FULL_SCALE;
                ramp_sub    <= 1'b1;
                state       <= S_MUL;
              end else begin
                level <= regs.sustain;
                state <= S_EMIT;
              end
            end
            PH_RELEASE: begin
              if (c_rel) begin
                cmd.operand <= c_fwd ? SH_W'(dt_fwd) : SH_W'(dt_back);
                cmd.mcand   <= release_slope;
                ramp_base   <= regs.sustain;
                ramp_sub    <= c_fwd;
                state       <= S_MUL;
              end else begin
                level <= '0;
                mode  <= PH_SILENCE;
                state <= S_EMIT;
              end
            end
            default: begin
              level <= '0;
              mode  <= PH_SILENCE;
              state <= S_EMIT;
            end
          endcase
        end
        S_MUL: begin
          if (stat.done) begin
            level <= ramp_sub ? sub_lvl : add_lvl;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_DATA_W'({mode, level});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_DIV_ATK || state == S_DIV_DEC ||
                   state == S_DIV_REL || state == S_MUL))
    else $error("serial unit finished with no step waiting");

  a_start_state: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (state == S_DIV_ATK || state == S_DIV_DEC ||
                   state == S_DIV_REL || state == S_MUL))
    else $error("serial unit started outside a waiting step");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LEVEL_W-1:0] <= FULL_SCALE))
    else $error("level above full scale");

endmodule
`default_nettype wire

FILE: hw/rtl/ahdsr_alu.sv
// shared serial unit: restoring divider and shift-add multiplier
`default_nettype none
module ahdsr_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  ahdsr_pkg::alu_cmd_t  cmd,
  output ahdsr_pkg::alu_stat_t stat
);
  import ahdsr_pkg::*;

  logic                busy;
  logic                done;
  alu_op_t             op;
  logic [CNT_W-1:0]    cnt;
  logic [SH_W-1:0]     sh;
  logic [REG_BITS-1:0] rem;
  logic [PROD_W-1:0]   acc;
  logic [REG_BITS-1:0] divisor;
  logic [SLOPE_W-1:0]  mcand;

  logic [REG_BITS:0]   trial;
  logic [REG_BITS+1:0] diff;
  logic                ge;
  logic [PROD_W-1:0]   acc_next;

  assign trial    = {rem, sh[SH_W-1]};
  assign diff     = {1'b0, trial} - (REG_BITS+2)'(divisor);
  assign ge       = !diff[REG_BITS+1];
  assign acc_next = {acc[PROD_W-2:0], 1'b0} + (sh[SH_W-1] ? PROD_W'(mcand) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !cmd.start && (cnt == CNT_W'(1));
      if (cmd.start) begin
        busy    <= 1'b1;
        op      <= cmd.op;
        divisor <= cmd.divisor;
        mcand   <= cmd.mcand;
        rem     <= '0;
        acc     <= '0;
        if (cmd.op == OP_DIV) begin
          sh  <= cmd.operand << DIV_ALIGN;
          cnt <= CNT_W'(DIVD_W);
        end else begin
          sh  <= cmd.operand << MUL_ALIGN;
          cnt <= CNT_W'(TIME_BITS);
        end
      end else if (busy) begin
        if (op == OP_DIV) begin
          rem <= ge ? diff[REG_BITS-1:0] : trial[REG_BITS-1:0];
          sh  <= {sh[SH_W-2:0], ge};
        end else begin
          acc <= acc_next;
          sh  <= {sh[SH_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = sh[DIVD_W-1:0];
  assign stat.prod = acc;

endmodule
`default_nettype wire

FILE: hw/rtl/ahdsr_cfg.sv
// configuration register file with sustain level clamp
`default_nettype none
module ahdsr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ahdsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ahdsr_pkg::REG_BITS-1:0]      cfg_data,
  output ahdsr_pkg::cfg_regs_t                regs
);
  import ahdsr_pkg::*;

  logic [REG_BITS-1:0] attack;
  logic [REG_BITS-1:0] hold;
  logic [REG_BITS-1:0] decay;
  logic [LEVEL_W-1:0]  sustain;
  logic [REG_BITS-1:0] release_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack      <= ATTACK_RESET;
      hold        <= HOLD_RESET;
      decay       <= DECAY_RESET;
      sustain     <= SUSTAIN_RESET;
      release_len <= RELEASE_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ATTACK:  attack      <= cfg_data;
        REG_HOLD:    hold        <= cfg_data;
        REG_DECAY:   decay       <= cfg_data;
        REG_SUSTAIN: sustain     <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE: release_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign regs.attack      = attack;
  assign regs.hold        = hold;
  assign regs.decay       = decay;
  assign regs.sustain     = (sustain > FULL_SCALE) ? FULL_SCALE : sustain;
  assign regs.release_len = release_len;

endmodule
`default_nettype wire
